/* src/ccr_pkg.sv */
// Shared types, constants and the CRC-16/CCITT byte step for the chunk reassembler.
`timescale 1ns / 1ps

package ccr_pkg;

  localparam int MaxPayload = 25;
  localparam int MaxChunks  = 16;
  localparam int FrameBytes = 32;
  localparam int HdrBytes   = 5;
  localparam int MinFrame   = 7;

  localparam logic [15:0] CrcInitReset = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'h1021;

  // request kinds
  localparam logic ReqFrame = 1'b0;
  localparam logic ReqRead  = 1'b1;

  // result kinds
  localparam logic KindVerdict = 1'b0;
  localparam logic KindData    = 1'b1;

  // verdict codes
  localparam logic [2:0] VerdShort    = 3'd0;
  localparam logic [2:0] VerdSizeBad  = 3'd1;
  localparam logic [2:0] VerdRangeBad = 3'd2;
  localparam logic [2:0] VerdCrcBad   = 3'd3;
  localparam logic [2:0] VerdAccepted = 3'd4;
  localparam logic [2:0] VerdComplete = 3'd5;
  localparam logic [2:0] VerdNoData   = 3'd6;

  // configuration register addresses (byte addresses)
  localparam logic [1:0] AddrCrcInit = 2'd0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] frame_byte;
    logic       frame_end;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] verdict;
    logic [7:0] ack_packet_id;
    logic [7:0] ack_chunk_id;
    logic [7:0] ack_check;
    logic [7:0] msg_type;
    logic [7:0] msg_id;
    logic [7:0] data_out;
    logic       data_last;
  } rsp_t;

  // One byte of CRC-16/CCITT, MSB first, no reflection.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* src/ccr_chunk_mem.sv */
// Chunk byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module ccr_chunk_mem #(
  parameter int Depth = (ccr_pkg::MaxChunks + 1) * ccr_pkg::MaxPayload,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/crc_checked_chunk_reassembler.sv */
// Top level of the CRC-checked chunk reassembler.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | in        | in_valid_i/in_stall_o | ccr_pkg::req_t (byte or read)
//   out     | out       | out_valid_o/out_stall_i | ccr_pkg::rsp_t (verdict/data)
//   cfg     | in        | APB psel/penable      | crc_initial_value at 0x0
//
// One request per cycle unless a result waits under out_stall_i; a result
// appears in the output register in the cycle after its request is taken.
// The chunk store is a single-port-write, single-port-read memory; a frame
// byte in a payload position writes it once and every read request reads it
// at most once, so the rate is one request per clock while nothing stalls.
// Reset is asynchronous and clears all control state; the chunk store needs
// no clearing pass. While a result waits under out_stall_i, requests stall.
`timescale 1ns / 1ps

module crc_checked_chunk_reassembler #(
  parameter int MAX_PAYLOAD = ccr_pkg::MaxPayload,
  parameter int MAX_CHUNKS  = ccr_pkg::MaxChunks,
  parameter int FRAME_BYTES = ccr_pkg::FrameBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // requests
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ccr_pkg::req_t in_data_i,
  // results
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ccr_pkg::rsp_t out_data_o,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // Buffers: one per slot plus one spare that takes the frame in flight.
  localparam int NumBuf = MAX_CHUNKS + 1;
  localparam int BufW   = $clog2(NumBuf);
  localparam int SlotW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int OffW   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LenW   = $clog2(MAX_PAYLOAD + 1);
  localparam int CntW   = $clog2(FRAME_BYTES + 2);
  localparam int Depth  = NumBuf * MAX_PAYLOAD;
  localparam int AddrW  = $clog2(Depth);
  localparam int CmpW   = 10;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [15:0] crc_init_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ccr_pkg::AddrCrcInit);
  assign prdata = (paddr == ccr_pkg::AddrCrcInit) ? {16'h0000, crc_init_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= ccr_pkg::CrcInitReset;
    end else if (cfg_wr) begin
      crc_init_q <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the output register parts the two sides
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic take;
  logic is_frame;
  logic is_read;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign is_frame   = take && (in_data_i.req_type == ccr_pkg::ReqFrame);
  assign is_read    = take && (in_data_i.req_type == ccr_pkg::ReqRead);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]  cnt_q;
  logic [15:0]      crc_q;
  logic [7:0]       hdr_type_q, hdr_id_q, hdr_size_q, hdr_idx_q, hdr_total_q;
  logic [BufW-1:0]  map_q [MAX_CHUNKS];
  logic [BufW-1:0]  spare_q;
  logic [LenW-1:0]  len_q [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] present_q;
  logic [7:0]       acc_q, exp_q, ltype_q, lid_q;
  logic             done_q;
  logic [SlotW-1:0] slot_q;
  logic [OffW-1:0]  off_q;

  // ---------------------------------------------------------------------------
  // Frame path: bytewise CRC, header capture, verdict on the last byte
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]  cnt_n;
  logic [15:0]      crc_cur, crc_new;
  logic [CmpW-1:0]  n_ext, size_ext;
  logic [7:0]       tot_eff;
  logic [2:0]       fverd;
  logic             fgood;
  logic [7:0]       acc_inc;
  logic             pay_we;
  logic [OffW-1:0]  pay_off;
  logic [AddrW-1:0] waddr;
  logic [15:0]      ack_crc;
  logic [SlotW-1:0] hidx;

  always_comb begin
    cnt_n    = (cnt_q <= CntW'(FRAME_BYTES)) ? cnt_q + CntW'(1) : cnt_q;
    crc_cur  = (cnt_q == '0) ? crc_init_q : crc_q;
    crc_new  = ccr_pkg::crc_byte(crc_cur, in_data_i.frame_byte);
    n_ext    = CmpW'(cnt_n);
    size_ext = CmpW'(hdr_size_q);
    tot_eff  = (acc_q == 8'd0) ? hdr_total_q : exp_q;
    hidx     = hdr_idx_q[SlotW-1:0];
    acc_inc  = (acc_q != 8'hFF) ? acc_q + 8'd1 : acc_q;
    fgood    = 1'b0;
    if (n_ext < CmpW'(ccr_pkg::MinFrame)) begin
      fverd = ccr_pkg::VerdShort;
    end else if (size_ext > CmpW'(MAX_PAYLOAD)
                 || size_ext + CmpW'(ccr_pkg::MinFrame) > CmpW'(FRAME_BYTES)
                 || n_ext != size_ext + CmpW'(ccr_pkg::MinFrame)) begin
      fverd = ccr_pkg::VerdSizeBad;
    end else if (CmpW'(tot_eff) > CmpW'(MAX_CHUNKS) || hdr_idx_q >= tot_eff) begin
      fverd = ccr_pkg::VerdRangeBad;
    end else if (crc_new != 16'h0000) begin
      fverd = ccr_pkg::VerdCrcBad;
    end else begin
      fgood = 1'b1;
      fverd = (acc_inc == tot_eff) ? ccr_pkg::VerdComplete : ccr_pkg::VerdAccepted;
    end
    ack_crc = ccr_pkg::crc_byte(ccr_pkg::crc_byte(crc_init_q, hdr_id_q), hdr_idx_q);

    // payload bytes go straight into the spare buffer
    pay_we  = is_frame && (CmpW'(cnt_q) >= CmpW'(ccr_pkg::HdrBytes))
              && (CmpW'(cnt_q) < CmpW'(ccr_pkg::HdrBytes + MAX_PAYLOAD));
    pay_off = OffW'(CmpW'(cnt_q) - CmpW'(ccr_pkg::HdrBytes));
    waddr   = AddrW'(spare_q) * AddrW'(MAX_PAYLOAD) + AddrW'(pay_off);
  end

  // ---------------------------------------------------------------------------
  // Read path: seek the current byte, read it, seek the following one
  // ---------------------------------------------------------------------------
  logic [MAX_CHUNKS-1:0] nonempty;
  logic             cur_ok, f1, f2;
  logic [SlotW-1:0] n1, n2, pos_s;
  logic [OffW-1:0]  pos_o;
  logic             rd_hit, rd_last, rd_none;
  logic [AddrW-1:0] raddr;

  always_comb begin
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      nonempty[i] = present_q[i] && (len_q[i] != '0) && (8'(i) < exp_q);
    end
    cur_ok = nonempty[slot_q] && (LenW'(off_q) < len_q[slot_q]);
    f1 = 1'b0;
    n1 = '0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (nonempty[i] && (SlotW'(i) > slot_q)) begin
        f1 = 1'b1;
        n1 = SlotW'(i);
      end
    end
    pos_s = cur_ok ? slot_q : n1;
    pos_o = cur_ok ? off_q : '0;
    f2 = 1'b0;
    n2 = '0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (nonempty[i] && (SlotW'(i) > pos_s)) begin
        f2 = 1'b1;
        n2 = SlotW'(i);
      end
    end
    rd_none = is_read && done_q && !cur_ok && !f1;
    rd_hit  = is_read && done_q && (cur_ok || f1);
    rd_last = (LenW'(pos_o) + LenW'(1) >= len_q[pos_s]) && !f2;
    raddr   = AddrW'(map_q[pos_s]) * AddrW'(MAX_PAYLOAD) + AddrW'(pos_o);
  end

  logic [7:0] mem_rdata;

  ccr_chunk_mem #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.frame_byte),
    .re_i    (rd_hit),
    .raddr_i (raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------------
  logic frame_ok;
  logic clear_store;

  assign frame_ok    = is_frame && in_data_i.frame_end && fgood;
  assign clear_store = rd_none || (rd_hit && rd_last);

  // header bytes and slot lengths carry no reset
  always_ff @(posedge clk_i) begin
    if (is_frame) begin
      crc_q <= crc_new;
      if (cnt_q == CntW'(0)) hdr_type_q  <= in_data_i.frame_byte;
      if (cnt_q == CntW'(1)) hdr_id_q    <= in_data_i.frame_byte;
      if (cnt_q == CntW'(2)) hdr_size_q  <= in_data_i.frame_byte;
      if (cnt_q == CntW'(3)) hdr_idx_q   <= in_data_i.frame_byte;
      if (cnt_q == CntW'(4)) hdr_total_q <= in_data_i.frame_byte;
    end
    if (frame_ok) begin
      len_q[hidx] <= LenW'(hdr_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        map_q[i] <= BufW'(i);
      end
      spare_q   <= BufW'(MAX_CHUNKS);
      present_q <= '0;
      acc_q     <= '0;
      exp_q     <= '0;
      ltype_q   <= '0;
      lid_q     <= '0;
      done_q    <= 1'b0;
      slot_q    <= '0;
      off_q     <= '0;
    end else begin
      if (is_frame) begin
        cnt_q <= in_data_i.frame_end ? '0 : cnt_n;
      end
      if (frame_ok) begin
        // swap the filled spare buffer into the slot, retire the old one
        map_q[hidx]     <= spare_q;
        spare_q         <= map_q[hidx];
        present_q[hidx] <= 1'b1;
        acc_q           <= acc_inc;
        if (acc_q == 8'd0) begin
          ltype_q <= hdr_type_q;
          lid_q   <= hdr_id_q;
          exp_q   <= hdr_total_q;
        end
        if (fverd == ccr_pkg::VerdComplete) begin
          done_q <= 1'b1;
        end
      end
      if (clear_store) begin
        present_q <= '0;
        acc_q     <= '0;
        exp_q     <= '0;
        done_q    <= 1'b0;
        slot_q    <= '0;
        off_q     <= '0;
      end else if (rd_hit) begin
        if (LenW'(pos_o) + LenW'(1) < len_q[pos_s]) begin
          slot_q <= pos_s;
          off_q  <= pos_o + OffW'(1);
        end else begin
          slot_q <= n2;
          off_q  <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  ccr_pkg::rsp_t rsp_d, rsp_q;
  logic          use_mem_q;
  logic          out_load;

  assign out_load = is_read || (is_frame && in_data_i.frame_end);

  always_comb begin
    rsp_d = '0;
    if (is_read) begin
      rsp_d.result_kind = ccr_pkg::KindData;
      rsp_d.verdict     = rd_hit ? ccr_pkg::VerdShort : ccr_pkg::VerdNoData;
      rsp_d.data_last   = rd_hit && rd_last;
      rsp_d.msg_type    = ltype_q;
      rsp_d.msg_id      = lid_q;
    end else begin
      rsp_d.result_kind = ccr_pkg::KindVerdict;
      rsp_d.verdict     = fverd;
      rsp_d.msg_type    = (fgood && acc_q == 8'd0) ? hdr_type_q : ltype_q;
      rsp_d.msg_id      = (fgood && acc_q == 8'd0) ? hdr_id_q : lid_q;
      if (fgood) begin
        rsp_d.ack_packet_id = hdr_id_q;
        rsp_d.ack_chunk_id  = hdr_idx_q;
        rsp_d.ack_check     = ack_crc[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= take && out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && out_load) begin
      rsp_q     <= rsp_d;
      use_mem_q <= rd_hit;
    end
  end

  always_comb begin
    out_data_o          = rsp_q;
    out_data_o.data_out = use_mem_q ? mem_rdata : 8'h00;
  end

  assign out_valid_o = out_valid_q;

endmodule

/* test/tb.sv */
// Testbench for the CRC-checked chunk reassembler: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb;
  import ccr_pkg::*;

  // Scoreboard: a private model of the reassembler that queues predicted results.
  class reassembly_scoreboard;
    logic [15:0] crc_init;
    logic [7:0]  stage [FrameBytes];
    int unsigned nbytes;
    logic [15:0] crc_run;
    logic [7:0]  store [MaxChunks*MaxPayload];
    int unsigned clen [MaxChunks];
    bit          present [MaxChunks];
    int unsigned accepted, total_exp;
    logic [7:0]  l_type, l_id;
    bit          done;
    int unsigned rslot, roff;
    rsp_t        pending [$];
    int          errors;

    function void reset_state();
      crc_init = CrcInitReset;
      nbytes = 0;
      crc_run = CrcInitReset;
      l_type = 0;
      l_id = 0;
      errors = 0;
      for (int i = 0; i < MaxChunks; i++) clen[i] = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      for (int i = 0; i < MaxChunks; i++) present[i] = 0;
      accepted = 0;
      total_exp = 0;
      done = 0;
      rslot = 0;
      roff = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
      return r;
    endfunction

    function bit find_byte();
      while (rslot < total_exp && rslot < MaxChunks) begin
        if (present[rslot] && roff < clen[rslot]) return 1;
        rslot++;
        roff = 0;
      end
      return 0;
    endfunction

    function void judge_frame(ref rsp_t r);
      int unsigned sz, idx, tot;
      logic [15:0] ack;
      if (nbytes < MinFrame) begin
        r.verdict = VerdShort;
        return;
      end
      sz = stage[2];
      if (sz > MaxPayload || MinFrame + sz > FrameBytes || nbytes != MinFrame + sz) begin
        r.verdict = VerdSizeBad;
        return;
      end
      idx = stage[3];
      tot = (accepted == 0) ? stage[4] : total_exp;
      if (tot > MaxChunks || idx >= tot) begin
        r.verdict = VerdRangeBad;
        return;
      end
      if (crc_run != 0) begin
        r.verdict = VerdCrcBad;
        return;
      end
      if (accepted == 0) begin
        l_type = stage[0];
        l_id = stage[1];
        total_exp = stage[4];
      end
      for (int k = 0; k < sz; k++) store[idx*MaxPayload + k] = stage[HdrBytes + k];
      clen[idx] = sz;
      present[idx] = 1;
      if (accepted < 255) accepted++;
      ack = crc_step(crc_step(crc_init, stage[1]), stage[3]);
      r.ack_packet_id = stage[1];
      r.ack_chunk_id = stage[3];
      r.ack_check = ack[7:0];
      if (accepted == total_exp) begin
        done = 1;
        r.verdict = VerdComplete;
      end else begin
        r.verdict = VerdAccepted;
      end
    endfunction

    // Note one accepted request and queue its result, if any.
    function void note_request(req_t q);
      rsp_t r;
      r = '0;
      if (q.req_type == ReqFrame) begin
        if (nbytes == 0) crc_run = crc_init;
        crc_run = crc_step(crc_run, q.frame_byte);
        if (nbytes < FrameBytes) stage[nbytes] = q.frame_byte;
        if (nbytes <= FrameBytes) nbytes++;
        if (!q.frame_end) return;
        r.result_kind = KindVerdict;
        judge_frame(r);
        nbytes = 0;
        crc_run = crc_init;
      end else begin
        r.result_kind = KindData;
        if (!done) begin
          r.verdict = VerdNoData;
        end else if (!find_byte()) begin
          r.verdict = VerdNoData;
          clear_msg();
        end else begin
          r.data_out = store[rslot*MaxPayload + roff];
          roff++;
          if (!find_byte()) begin
            r.data_last = 1;
            clear_msg();
          end
        end
      end
      r.msg_type = l_type;
      r.msg_id = l_id;
      pending = {pending, r};
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch, expected %h, actual %h", $realtime, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  req_t in_data_i;
  rsp_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  crc_checked_chunk_reassembler DUT (.*);

  reassembly_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int quiet_cycles;
  req_t frame_buf [$];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: stall at random, or hold off completely during the pressure stretch.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Score results and run the watchdog on accepted traffic.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one request; hold it until the block takes it. Valid stays high
  // for a following request; idle cycles and drain() drop it.
  task automatic send_request(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(q);
  endtask

  task automatic cfg_write(logic [15:0] v);
    psel <= 1; pwrite <= 1; paddr <= AddrCrcInit; pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.crc_init = v;
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Build a frame; damage selects a broken variant.
  task automatic make_frame(logic [7:0] typ, logic [7:0] id, int sz, logic [7:0] idx,
                            logic [7:0] tot, int damage);
    logic [7:0] b [$];
    logic [15:0] c;
    req_t q;
    b = {typ, id, 8'(sz), idx, tot};
    for (int k = 0; k < sz; k++) b = {b, 8'($urandom)};
    c = sb.crc_init;
    foreach (b[k]) c = sb.crc_step(c, b[k]);
    b = {b, c[15:8]};
    b = {b, c[7:0]};
    case (damage)
      1: b[b.size()-1] ^= 8'(1 << $urandom_range(7));
      2: b = {b, 8'($urandom)};
      3: b.pop_back();
      4: while (b.size() > 1 + $urandom_range(5)) b.pop_back();
      5: repeat (28) b = {b, 8'($urandom)};
      default: ;
    endcase
    frame_buf.delete();
    foreach (b[k]) begin
      q.req_type = ReqFrame;
      q.frame_byte = b[k];
      q.frame_end = (k == b.size() - 1);
      frame_buf = {frame_buf, q};
    end
  endtask

  task automatic send_frame();
    foreach (frame_buf[k]) send_request(frame_buf[k]);
  endtask

  task automatic send_read();
    req_t q;
    q.req_type = ReqRead;
    q.frame_byte = 8'($urandom);
    q.frame_end = $urandom_range(1);
    send_request(q);
  endtask

  // One message of tot chunks, in random order, with some noise and repeats.
  task automatic send_message(int tot, int max_sz);
    logic [7:0] typ, id;
    typ = 8'($urandom);
    id = 8'($urandom);
    for (int i = 0; i < tot; i++) begin
      if ($urandom_range(9) == 0) begin
        make_frame(typ, id, $urandom_range(max_sz), 8'($urandom_range(tot)), 8'(tot),
                   $urandom_range(1, 5));
        send_frame();
      end
      if ($urandom_range(9) == 0) send_read();
      make_frame(typ, id, $urandom_range(max_sz), 8'($urandom_range(tot - 1)), 8'(tot), 0);
      send_frame();
    end
    while (sb.done) send_read();
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    out_stall_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    hold_off = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reads with nothing done, every fault, extremes of the fields.
    send_read();
    make_frame(8'h00, 8'h00, 0, 0, 0, 0); send_frame();          // total zero
    make_frame(8'hff, 8'hff, 25, 0, 17, 0); send_frame();        // total too big
    make_frame(8'h12, 8'h34, 3, 0, 2, 4); send_frame();          // short
    make_frame(8'h12, 8'h34, 3, 0, 2, 5); send_frame();          // overlong
    make_frame(8'h12, 8'h34, 26, 0, 2, 0); send_frame();         // size too big
    make_frame(8'h12, 8'h34, 3, 0, 2, 2); send_frame();          // length mismatch
    make_frame(8'h12, 8'h34, 3, 0, 2, 1); send_frame();          // crc bad
    make_frame(8'h12, 8'h34, 25, 1, 2, 0); send_frame();
    make_frame(8'h12, 8'h34, 4, 1, 2, 0); send_frame();          // repeated index
    make_frame(8'h12, 8'h34, 0, 0, 2, 0); send_frame();          // empty chunk
    while (sb.done) send_read();
    send_read();
    make_frame(8'hff, 8'hff, 0, 15, 16, 0); send_frame();
    make_frame(8'hff, 8'hff, 0, 0, 1, 0); send_frame();          // wrong latched total
    drain();
    cfg_write(16'h0000);
    make_frame(8'h01, 8'h02, 0, 0, 1, 0); send_frame();          // empty message
    send_read();
    drain();
    cfg_write(16'hffff);

    // Random phases across idling mixes and register settings.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 34 : 63) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 34 : 63) : 0;
      for (int m = 0; m < 2; m++) send_message($urandom_range(1, 4), 6);
      if (ph == 0) begin
        // Hold off the receiver so the block fills and stalls its input.
        fork
          begin
            hold_off = 1;
            repeat (60) @(posedge clk_i);
            hold_off = 0;
          end
          repeat (8) send_read();
        join
      end
      drain();
      cfg_write((ph == 0) ? 16'h1d0f : 16'($urandom));
    end
    send_message(16, 12);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
